// ===== src/clr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clr_pkg: shared constants for the clipped line rasterizer.
// Outcode bits, function codes and the reset values of the surface size.
// ----------------------------------------------------------------------------
package clr_pkg;

  localparam int unsigned CoordBits = 16;
  localparam int unsigned DimBits   = 12;

  // Outcode bits of the clip window.
  localparam logic [3:0] OcLeft   = 4'd1;
  localparam logic [3:0] OcRight  = 4'd2;
  localparam logic [3:0] OcBottom = 4'd4;
  localparam logic [3:0] OcTop    = 4'd8;

  // Function codes of an input beat.
  localparam logic FuncLoad = 1'b0;
  localparam logic FuncStep = 1'b1;

  // Register indexes.
  localparam logic RegWidth  = 1'b0;
  localparam logic RegHeight = 1'b1;

  localparam logic [12:0] WidthReset  = 13'd640;
  localparam logic [12:0] HeightReset = 13'd480;

endpackage

// ===== src/clipped_line_rasterizer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clipped_line_rasterizer: Cohen-Sutherland clip and Bresenham line stepper.
// A load beat clips a line against the surface; step beats emit its pixels.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  in      | input     | in_valid/in_ready  | func, endpoints, color
//  out     | output    | out_valid/out_ready| pixel, flags
//  cfg     | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// A step beat computes its pixel, then hands over the result register. A load
// takes up to eight clip passes; each pass runs one restoring divider, one
// quotient bit per cycle over the product width. Reset clears all control
// state and the surface size returns to 640 by 480. The input stalls while a
// result waits in the output register.
module clipped_line_rasterizer #(
  parameter int unsigned COORD_BITS = clr_pkg::CoordBits
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  func_i,
  input  logic [COORD_BITS-1:0] start_x_i,
  input  logic [COORD_BITS-1:0] start_y_i,
  input  logic [COORD_BITS-1:0] end_x_i,
  input  logic [COORD_BITS-1:0] end_y_i,
  input  logic [23:0]           line_color_i,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  pixel_valid_o,
  output logic [11:0]           pixel_x_o,
  output logic [11:0]           pixel_y_o,
  output logic [23:0]           pixel_color_o,
  output logic                  last_pixel_o,
  output logic                  line_visible_o,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic                  cfg_index,
  input  logic [12:0]           cfg_data
);

  // Coordinates carry two extra bits; the product and divider are wider.
  localparam int unsigned CW = COORD_BITS + 2;
  localparam int unsigned PW = 2 * CW;
  localparam int unsigned QW = $clog2(PW + 1);
  localparam int unsigned DW = clr_pkg::DimBits + 1;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StCode = 3'd1;
  localparam logic [2:0] StMul  = 3'd2;
  localparam logic [2:0] StDiv  = 3'd3;
  localparam logic [2:0] StFix  = 3'd4;
  localparam logic [2:0] StOut  = 3'd5;

  logic [2:0] state_q, state_d;

  logic [12:0] width_q, height_q;

  // Clip working set.
  logic signed [CW-1:0] xa_q, ya_q, xb_q, yb_q;
  logic [3:0]           pass_q;
  logic [3:0]           co_q;
  logic                 co_is_a_q;
  logic signed [CW-1:0] right_s, top_s;

  // Divider registers.
  logic [PW-1:0] prod_q;
  logic [CW-1:0] dvs_q;
  logic [CW-1:0] rem_q;
  logic [QW-1:0] cnt_q;
  logic          qneg_q;

  // Line stepping state.
  logic [11:0]          cur_x_q, cur_y_q, stop_x_q, stop_y_q, span_x_q, span_y_q;
  logic                 step_x_neg_q, step_y_neg_q;
  logic signed [12:0]   error_term_q;
  logic [23:0]          held_color_q;
  logic                 line_active_q;

  // Result register.
  logic        out_valid_q;
  logic        pv_q, last_q, vis_q;
  logic [11:0] px_q, py_q;
  logic [23:0] pc_q;

  assign in_ready  = (state_q == StIdle) && !out_valid_q;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_q;
  assign pixel_valid_o = pv_q;
  assign pixel_x_o     = px_q;
  assign pixel_y_o     = py_q;
  assign pixel_color_o = pc_q;
  assign last_pixel_o  = last_q;
  assign line_visible_o = vis_q;

  // Effective window edges.
  logic [DW-1:0] wdim, hdim;
  always_comb begin
    if (width_q == '0) wdim = DW'(1);
    else if (width_q > 13'(1 << clr_pkg::DimBits)) wdim = DW'(1 << clr_pkg::DimBits);
    else wdim = DW'(width_q);
    if (height_q == '0) hdim = DW'(1);
    else if (height_q > 13'(1 << clr_pkg::DimBits)) hdim = DW'(1 << clr_pkg::DimBits);
    else hdim = DW'(height_q);
    right_s = CW'($signed({1'b0, wdim})) - CW'(1);
    top_s   = CW'($signed({1'b0, hdim})) - CW'(1);
  end

  function automatic logic [3:0] outcode(logic signed [CW-1:0] x, logic signed [CW-1:0] y,
                                         logic signed [CW-1:0] r, logic signed [CW-1:0] t);
    logic [3:0] c;
    c = '0;
    if (x < 0) c = c | clr_pkg::OcLeft;
    else if (x > r) c = c | clr_pkg::OcRight;
    if (y < 0) c = c | clr_pkg::OcBottom;
    else if (y > t) c = c | clr_pkg::OcTop;
    return c;
  endfunction

  logic [3:0] ca, cb, co;
  assign ca = outcode(xa_q, ya_q, right_s, top_s);
  assign cb = outcode(xb_q, yb_q, right_s, top_s);
  assign co = (ca != '0) ? ca : cb;

  // Operands of the current intersection: num * fac / den.
  logic signed [CW-1:0] num, fac, den;
  always_comb begin
    if ((co & clr_pkg::OcTop) != '0) begin
      num = xb_q - xa_q; fac = top_s - ya_q; den = yb_q - ya_q;
    end else if ((co & clr_pkg::OcBottom) != '0) begin
      num = xb_q - xa_q; fac = -ya_q; den = yb_q - ya_q;
    end else if ((co & clr_pkg::OcRight) != '0) begin
      num = yb_q - ya_q; fac = right_s - xa_q; den = xb_q - xa_q;
    end else begin
      num = yb_q - ya_q; fac = -xa_q; den = xb_q - xa_q;
    end
  end

  logic [CW-1:0] mnum, mfac, mden;
  assign mnum = num[CW-1] ? CW'(-num) : CW'(num);
  assign mfac = fac[CW-1] ? CW'(-fac) : CW'(fac);
  assign mden = den[CW-1] ? CW'(-den) : CW'(den);

  // Restoring divide step.
  logic [CW:0]   rem_sh;
  logic          rem_ge;
  assign rem_sh = {rem_q, prod_q[PW-1]};
  assign rem_ge = rem_sh >= {1'b0, dvs_q};

  // The intersection is always measured from the first endpoint.
  logic signed [CW-1:0] quot_s, base_s, newc_s;
  assign quot_s = qneg_q ? CW'(-$signed(prod_q[CW-1:0])) : $signed(prod_q[CW-1:0]);
  assign base_s = ((co_q & (clr_pkg::OcTop | clr_pkg::OcBottom)) != '0) ? xa_q : ya_q;
  assign newc_s = base_s + quot_s;

  // Bresenham next step.
  logic signed [13:0] e2;
  logic               at_end;
  assign e2     = {error_term_q, 1'b0};
  assign at_end = (cur_x_q == stop_x_q) && (cur_y_q == stop_y_q);

  logic signed [CW-1:0] sx, sy, ex, ey;
  always_comb begin
    sx = CW'($signed(start_x_i)); sy = CW'($signed(start_y_i));
    ex = CW'($signed(end_x_i));   ey = CW'($signed(end_y_i));
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: if (in_valid && in_ready) begin
        state_d = (func_i == clr_pkg::FuncLoad) ? StCode : StIdle;
      end
      StCode: begin
        if ((ca | cb) == '0 || (ca & cb) != '0 || pass_q == 4'd8) state_d = StOut;
        else state_d = StMul;
      end
      StMul: state_d = StDiv;
      StDiv: if (cnt_q == QW'(PW - 1)) state_d = StFix;
      StFix: state_d = StCode;
      StOut: state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= StIdle;
      width_q       <= clr_pkg::WidthReset;
      height_q      <= clr_pkg::HeightReset;
      out_valid_q   <= 1'b0;
      line_active_q <= 1'b0;
      cur_x_q <= '0; cur_y_q <= '0; stop_x_q <= '0; stop_y_q <= '0;
      span_x_q <= '0; span_y_q <= '0; step_x_neg_q <= 1'b0; step_y_neg_q <= 1'b0;
      error_term_q <= '0; held_color_q <= '0;
      pass_q <= '0; cnt_q <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == clr_pkg::RegWidth) width_q <= cfg_data;
        else height_q <= cfg_data;
      end
      if (out_valid_q && out_ready) out_valid_q <= 1'b0;
      case (state_q)
        StIdle: if (in_valid && in_ready) begin
          if (func_i == clr_pkg::FuncLoad) begin
            held_color_q  <= line_color_i;
            line_active_q <= 1'b0;
            pass_q        <= '0;
            if (sy > ey) begin
              xa_q <= ex; ya_q <= ey; xb_q <= sx; yb_q <= sy;
            end else begin
              xa_q <= sx; ya_q <= sy; xb_q <= ex; yb_q <= ey;
            end
          end else begin
            out_valid_q <= 1'b1;
            vis_q <= 1'b0;
            pv_q  <= line_active_q;
            px_q  <= line_active_q ? cur_x_q : '0;
            py_q  <= line_active_q ? cur_y_q : '0;
            pc_q  <= line_active_q ? held_color_q : '0;
            last_q <= line_active_q && at_end;
            if (line_active_q) begin
              if (at_end) line_active_q <= 1'b0;
              else begin
                error_term_q <= error_term_q
                  - ((e2 > -$signed({2'b0, span_y_q})) ? $signed({1'b0, span_y_q}) : 13'sd0)
                  + ((e2 < $signed({2'b0, span_x_q})) ? $signed({1'b0, span_x_q}) : 13'sd0);
                if (e2 > -$signed({2'b0, span_y_q}))
                  cur_x_q <= step_x_neg_q ? cur_x_q - 12'd1 : cur_x_q + 12'd1;
                if (e2 < $signed({2'b0, span_x_q}))
                  cur_y_q <= step_y_neg_q ? cur_y_q - 12'd1 : cur_y_q + 12'd1;
              end
            end
          end
        end
        StCode: begin
          co_q      <= co;
          co_is_a_q <= (ca != '0);
          qneg_q    <= (num[CW-1] ^ fac[CW-1]) ^ den[CW-1];
          dvs_q     <= mden;
          vis_q     <= ((ca | cb) == '0);
          if ((ca | cb) == '0) begin
            cur_x_q  <= xa_q[11:0]; cur_y_q <= ya_q[11:0];
            stop_x_q <= xb_q[11:0]; stop_y_q <= yb_q[11:0];
            span_x_q <= (xb_q > xa_q) ? 12'(xb_q - xa_q) : 12'(xa_q - xb_q);
            span_y_q <= (yb_q > ya_q) ? 12'(yb_q - ya_q) : 12'(ya_q - yb_q);
            step_x_neg_q <= !(xa_q < xb_q);
            step_y_neg_q <= !(ya_q < yb_q);
            error_term_q <= 13'((xb_q > xa_q ? xb_q - xa_q : xa_q - xb_q)
                              - (yb_q > ya_q ? yb_q - ya_q : ya_q - yb_q));
            line_active_q <= 1'b1;
          end
          prod_q <= PW'(mnum) * PW'(mfac);
        end
        StMul: begin
          rem_q <= '0;
          cnt_q <= '0;
        end
        StDiv: begin
          rem_q  <= rem_ge ? CW'(rem_sh - {1'b0, dvs_q}) : CW'(rem_sh);
          prod_q <= {prod_q[PW-2:0], rem_ge};
          cnt_q  <= cnt_q + QW'(1);
        end
        StFix: begin
          pass_q <= pass_q + 4'd1;
          if ((co_q & clr_pkg::OcTop) != '0) begin
            if (co_is_a_q) begin xa_q <= (dvs_q == '0) ? xa_q : newc_s; ya_q <= top_s; end
            else begin xb_q <= (dvs_q == '0) ? xa_q : newc_s; yb_q <= top_s; end
          end else if ((co_q & clr_pkg::OcBottom) != '0) begin
            if (co_is_a_q) begin xa_q <= (dvs_q == '0) ? xa_q : newc_s; ya_q <= '0; end
            else begin xb_q <= (dvs_q == '0) ? xa_q : newc_s; yb_q <= '0; end
          end else if ((co_q & clr_pkg::OcRight) != '0) begin
            if (co_is_a_q) begin ya_q <= (dvs_q == '0) ? ya_q : newc_s; xa_q <= right_s; end
            else begin yb_q <= (dvs_q == '0) ? ya_q : newc_s; xb_q <= right_s; end
          end else begin
            if (co_is_a_q) begin ya_q <= (dvs_q == '0) ? ya_q : newc_s; xa_q <= '0; end
            else begin yb_q <= (dvs_q == '0) ? ya_q : newc_s; xb_q <= '0; end
          end
        end
        StOut: begin
          out_valid_q <= 1'b1;
          pv_q <= 1'b0; px_q <= '0; py_q <= '0; pc_q <= '0; last_q <= 1'b0;
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== tb/clipped_line_rasterizer_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clipped_line_rasterizer_tb: self-checking bench for the line rasterizer.
// Load and step beats are driven over the valid/ready input channel. A
// behavioral clip-and-step predictor queues the expected result of each
// accepted beat, and a checker compares every output beat field by field.
// Surface sizes, including the out-of-range extremes, are swept through the
// configuration channel between phases. Both channels idle at random.
// ----------------------------------------------------------------------------
module clipped_line_rasterizer_tb;

  localparam int unsigned CycleLimit = 3000000;
  localparam int unsigned DrainCycles = 400;

  typedef struct packed {
    logic        pix;
    logic [11:0] x;
    logic [11:0] y;
    logic [23:0] color;
    logic        last;
    logic        visible;
  } pixel_beat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic func = clr_pkg::FuncStep;
  logic [15:0] sx = '0, sy = '0, ex = '0, ey = '0;
  logic [23:0] color = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic pix_valid, last_pix, visible;
  logic [11:0] pix_x, pix_y;
  logic [23:0] pix_color;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = clr_pkg::RegWidth;
  logic [12:0] cfg_data = '0;

  // Predictor state: surface size and the active line.
  logic [12:0] surf_w = clr_pkg::WidthReset, surf_h = clr_pkg::HeightReset;
  int pos_x, pos_y, end_px, end_py, run_x, run_y, err;
  bit neg_x, neg_y, drawing;
  logic [23:0] ink;

  pixel_beat_t pending_pixels[$];
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned loads_sent = 0, pixels_seen = 0, lines_visible = 0;
  bit calm = 1'b0;

  clipped_line_rasterizer i_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .func_i(func), .start_x_i(sx), .start_y_i(sy), .end_x_i(ex), .end_y_i(ey),
    .line_color_i(color),
    .out_valid(out_valid), .out_ready(out_ready),
    .pixel_valid_o(pix_valid), .pixel_x_o(pix_x), .pixel_y_o(pix_y),
    .pixel_color_o(pix_color), .last_pixel_o(last_pix), .line_visible_o(visible),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Cycle counter with a hard stop.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Receiver stalls in bursts, none once the bench goes calm.
  int unsigned ready_left = 0;
  always @(posedge clk) begin
    if (calm) begin
      out_ready <= 1'b1;
    end else if (ready_left == 0) begin
      ready_left <= $urandom_range(1, 12);
      out_ready <= ($urandom_range(0, 2) != 0);
    end else begin
      ready_left <= ready_left - 1;
    end
  end

  function automatic longint dim_eff(logic [12:0] r);
    if (r == 0) return 1;
    if (r > 4096) return 4096;
    return longint'(r);
  endfunction

  function automatic logic [3:0] region(longint x, longint y, longint rgt, longint tp);
    logic [3:0] c;
    c = '0;
    if (x < 0) c |= clr_pkg::OcLeft;
    else if (x > rgt) c |= clr_pkg::OcRight;
    if (y < 0) c |= clr_pkg::OcBottom;
    else if (y > tp) c |= clr_pkg::OcTop;
    return c;
  endfunction

  // Truncating a*b/c; the product stays well inside 64 bits.
  function automatic longint scaled(longint a, longint b, longint c);
    if (c == 0) return 0;
    return (a * b) / c;
  endfunction

  // Clip a line and set it up for stepping; returns the visibility flag.
  function automatic bit clip_line(logic [15:0] x0, y0, x1, y1, logic [23:0] c);
    longint rgt, tp, xa, ya, xb, yb, x, y, t;
    logic [3:0] ca, cb, co;
    bit acc;
    rgt = dim_eff(surf_w) - 1;
    tp = dim_eff(surf_h) - 1;
    xa = $signed(x0); ya = $signed(y0); xb = $signed(x1); yb = $signed(y1);
    acc = 1'b0;
    ink = c;
    drawing = 1'b0;
    if (ya > yb) begin
      t = xa; xa = xb; xb = t;
      t = ya; ya = yb; yb = t;
    end
    ca = region(xa, ya, rgt, tp);
    cb = region(xb, yb, rgt, tp);
    for (int pass = 0; pass <= 8; pass++) begin
      if ((ca | cb) == 0) begin
        acc = 1'b1;
        break;
      end
      if ((ca & cb) != 0 || pass == 8) break;
      co = (ca != 0) ? ca : cb;
      if ((co & clr_pkg::OcTop) != 0) begin
        x = xa + scaled(xb - xa, tp - ya, yb - ya); y = tp;
      end else if ((co & clr_pkg::OcBottom) != 0) begin
        x = xa + scaled(xb - xa, -ya, yb - ya); y = 0;
      end else if ((co & clr_pkg::OcRight) != 0) begin
        y = ya + scaled(yb - ya, rgt - xa, xb - xa); x = rgt;
      end else begin
        y = ya + scaled(yb - ya, -xa, xb - xa); x = 0;
      end
      if (co == ca) begin
        xa = x; ya = y; ca = region(xa, ya, rgt, tp);
      end else begin
        xb = x; yb = y; cb = region(xb, yb, rgt, tp);
      end
    end
    if (acc) begin
      pos_x = int'(xa); pos_y = int'(ya); end_px = int'(xb); end_py = int'(yb);
      run_x = (end_px > pos_x) ? end_px - pos_x : pos_x - end_px;
      run_y = (end_py > pos_y) ? end_py - pos_y : pos_y - end_py;
      neg_x = !(pos_x < end_px);
      neg_y = !(pos_y < end_py);
      err = run_x - run_y;
      drawing = 1'b1;
    end
    return acc;
  endfunction

  // Work out the result of one accepted beat and queue it.
  function automatic void predict_pixel(logic f, logic [15:0] x0, y0, x1, y1,
                                        logic [23:0] c);
    pixel_beat_t r;
    int e2;
    r = '0;
    if (f == clr_pkg::FuncLoad) begin
      r.visible = clip_line(x0, y0, x1, y1, c);
    end else if (drawing) begin
      r.pix = 1'b1;
      r.x = pos_x[11:0];
      r.y = pos_y[11:0];
      r.color = ink;
      if (pos_x == end_px && pos_y == end_py) begin
        r.last = 1'b1;
        drawing = 1'b0;
      end else begin
        e2 = 2 * err;
        if (e2 > -run_y) begin
          err -= run_y;
          pos_x += neg_x ? -1 : 1;
        end
        if (e2 < run_x) begin
          err += run_x;
          pos_y += neg_y ? -1 : 1;
        end
      end
    end
    pending_pixels.push_back(r);
  endfunction

  task automatic report(string what, int got, int want);
    $display("Mismatch in %s at cycle %0d: got %0h, expected %0h",
             what, cycle_count, got, want);
    error_count++;
  endtask

  // Compare each output beat with the oldest expectation.
  always @(posedge clk) begin
    pixel_beat_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_pixels.size() == 0) begin
        report("unexpected beat", 1, 0);
      end else begin
        want = pending_pixels.pop_front();
        if (pix_valid !== want.pix) report("pixel_valid", pix_valid, want.pix);
        if (pix_x !== want.x) report("pixel_x", pix_x, want.x);
        if (pix_y !== want.y) report("pixel_y", pix_y, want.y);
        if (pix_color !== want.color) report("pixel_color", pix_color, want.color);
        if (last_pix !== want.last) report("last_pixel", last_pix, want.last);
        if (visible !== want.visible) report("line_visible", visible, want.visible);
        if (pix_valid) pixels_seen++;
        if (visible) lines_visible++;
      end
    end
  end

  // Send one beat, then maybe leave a gap.
  task automatic send_beat(logic f, int x0, int y0, int x1, int y1, logic [23:0] c);
    func <= f;
    sx <= x0[15:0]; sy <= y0[15:0]; ex <= x1[15:0]; ey <= y1[15:0];
    color <= c;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    predict_pixel(f, x0[15:0], y0[15:0], x1[15:0], y1[15:0], c);
    if (f == clr_pkg::FuncLoad) loads_sent++;
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  task automatic draw(int x0, int y0, int x1, int y1, int steps);
    send_beat(clr_pkg::FuncLoad, x0, y0, x1, y1, 24'($urandom()));
    repeat (steps) send_beat(clr_pkg::FuncStep, 0, 0, 0, 0, 24'($urandom()));
  endtask

  // Let all results drain and the clip unit go quiet.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [12:0] value);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == clr_pkg::RegWidth) surf_w = value;
    else surf_h = value;
  endtask

  function automatic int pick(int lo, int hi);
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  // A random line: mostly near the window, sometimes anywhere.
  task automatic random_line();
    int w, h;
    w = int'(dim_eff(surf_w));
    h = int'(dim_eff(surf_h));
    if ($urandom_range(0, 6) == 0) begin
      draw($signed(16'($urandom())), $signed(16'($urandom())),
           $signed(16'($urandom())), $signed(16'($urandom())), pick(0, 8));
    end else begin
      draw(pick(-w / 2 - 2, w + w / 2 + 2), pick(-h / 2 - 2, h + h / 2 + 2),
           pick(-w / 2 - 2, w + w / 2 + 2), pick(-h / 2 - 2, h + h / 2 + 2),
           pick(0, 45));
    end
  endtask

  // Extremes, clip edges, degenerate lines, steps with no line.
  task automatic test_directed();
    send_beat(clr_pkg::FuncStep, 0, 0, 0, 0, 24'hFFFFFF);
    draw(-32768, -32768, 32767, 32767, 3);
    draw(32767, 32767, -32768, -32768, 2);
    draw(10, 10, 10, 10, 2);
    draw(0, 5, 639, 5, 2);
    draw(7, 479, 7, 0, 2);
    draw(-50, -10, -5, 300, 1);
    draw(100, 500, 300, 900, 1);
    draw(-100, 240, 800, 240, 1);
    draw(600, -40, 700, 100, 3);
  endtask

  // Surface sizes at and beyond the limits.
  task automatic test_surface_sizes();
    write_reg(clr_pkg::RegWidth, 13'h1FFF);
    write_reg(clr_pkg::RegHeight, 13'd0);
    draw(-5, -3, 5000, 2, 5);
    draw(4095, 0, 4096, 0, 3);
    write_reg(clr_pkg::RegWidth, 13'd1);
    write_reg(clr_pkg::RegHeight, 13'd1);
    draw(-3, -3, 3, 3, 3);
    draw(1, 0, 2, 0, 1);
    write_reg(clr_pkg::RegWidth, 13'd4096);
    write_reg(clr_pkg::RegHeight, 13'd4096);
    draw(-32768, 100, 32767, 4000, 4);
    draw(4095, 4095, 0, 0, 4);
  endtask

  task automatic test_random();
    write_reg(clr_pkg::RegWidth, 13'd32);
    write_reg(clr_pkg::RegHeight, 13'd24);
    repeat (5) random_line();
    wait_idle();
    repeat (6) random_line();
    write_reg(clr_pkg::RegWidth, 13'd200);
    write_reg(clr_pkg::RegHeight, 13'd13);
    repeat (6) random_line();
  endtask

  task automatic test_steady_stream();
    write_reg(clr_pkg::RegWidth, clr_pkg::WidthReset);
    write_reg(clr_pkg::RegHeight, clr_pkg::HeightReset);
    calm = 1'b1;
    repeat (2) random_line();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_surface_sizes();
    test_random();
    test_steady_stream();
    wait_idle();
    $display("Covered %0d line loads, %0d visible, %0d pixels across six surface sizes.",
             loads_sent, lines_visible, pixels_seen);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
